// ===== hw/rtl/bsr_pkg.sv =====
// Package for the bit store with get, set and range-any operations.
// Holds the transaction payload types, operation codes and sizing constants.
`timescale 1ns / 1ps

package bsr_pkg;

	localparam int unsigned NUM_BITS_DEF = 1024;
	localparam int unsigned WORD_BITS    = 32;
	localparam int unsigned POS_W        = 5;
	localparam int unsigned WIDX_W       = 5;

	localparam logic [1:0] OP_GET = 2'd0;
	localparam logic [1:0] OP_SET = 2'd1;
	localparam logic [1:0] OP_ANY = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [9:0]  bit_index;
		logic [10:0] range_end;
		logic        new_value;
	} req_t;

	typedef struct packed {
		logic answer_bit;
	} rsp_t;

endpackage

// ===== hw/rtl/bsr_stream_if.sv =====
// Valid/ready channel that carries one payload per transaction.
// The payload type is a parameter; it depends on nothing else.
`timescale 1ns / 1ps

interface bsr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/bitset_get_set_range_any.sv =====
// Get and set read the addressed word, then present the result (set writes the word back);
// any reads its range word by word up to a set bit or its last word. Empty ranges, indices
// out of range and unused codes skip the read. A request is taken only in ST_IDLE, entered
// as the previous result is presented; a word walk or an earlier result the receiver has
// not taken holds it off. Reset clears control state and then sweeps the memory to zero,
// one word a cycle, while no request is taken. Depends on bsr_pkg and bsr_stream_if.
`timescale 1ns / 1ps

module bitset_get_set_range_any #(
	parameter int unsigned NUM_BITS = bsr_pkg::NUM_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	bsr_stream_if.sink    req,
	bsr_stream_if.source  rsp
);
	import bsr_pkg::*;

	localparam int unsigned WC = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned AW = (WC > 1) ? $clog2(WC) : 1;

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_WALK, ST_DONE} state_t;

	state_t            state_q;
	logic [AW-1:0]     clr_addr_q;
	logic [1:0]        op_q;
	logic              val_q;
	logic [POS_W-1:0]  lo_q;
	logic [POS_W-1:0]  hi_q;
	logic [WIDX_W-1:0] w_q;
	logic [WIDX_W-1:0] first_q;
	logic [WIDX_W-1:0] last_q;
	logic              ans_q;
	logic              out_valid_q;
	logic              out_ans_q;

	logic [WORD_BITS-1:0] mem [WC];
	logic [WORD_BITS-1:0] rd_data_q;
	logic [AW-1:0]        rd_addr;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [WORD_BITS-1:0] wr_data;

	req_t        rq;
	logic [10:0] rc;
	logic [10:0] rc_m1;
	logic        idx_ok;
	logic        range_ok;

	logic [POS_W-1:0]     m_lo;
	logic [POS_W-1:0]     m_hi;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] onehot;
	logic                 hit;
	logic                 bit_sel;

	assign rq = req.data;
	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data.answer_bit = out_ans_q;

	assign rc       = (32'(rq.range_end) > NUM_BITS) ? 11'(NUM_BITS) : rq.range_end;
	assign rc_m1    = rc - 11'd1;
	assign idx_ok   = 32'(rq.bit_index) < NUM_BITS;
	assign range_ok = {1'b0, rq.bit_index} < rc;

	assign m_lo    = (w_q == first_q) ? lo_q : '0;
	assign m_hi    = (w_q == last_q) ? hi_q : POS_W'(WORD_BITS - 1);
	assign mask    = ({WORD_BITS{1'b1}} >> m_lo)
		& ({WORD_BITS{1'b1}} << (POS_W'(WORD_BITS - 1) - m_hi));
	assign onehot  = {1'b1, {(WORD_BITS - 1){1'b0}}} >> lo_q;
	assign hit     = |(rd_data_q & mask);
	assign bit_sel = |(rd_data_q & onehot);

	always_comb begin
		if (state_q == ST_WALK) begin
			rd_addr = AW'(w_q + WIDX_W'(1));
		end else begin
			rd_addr = AW'(rq.bit_index[9:5]);
		end
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else begin
			wr_en   = (state_q == ST_WALK) && (op_q == OP_SET);
			wr_addr = AW'(w_q);
			wr_data = val_q ? (rd_data_q | onehot) : (rd_data_q & ~onehot);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
			out_ans_q   <= 1'b0;
			op_q        <= OP_GET;
			val_q       <= 1'b0;
			lo_q        <= '0;
			hi_q        <= '0;
			w_q         <= '0;
			first_q     <= '0;
			last_q      <= '0;
			ans_q       <= 1'b0;
		end else begin
			if (rsp.ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(WC - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						op_q    <= rq.operation;
						val_q   <= rq.new_value;
						lo_q    <= rq.bit_index[4:0];
						hi_q    <= rc_m1[4:0];
						w_q     <= rq.bit_index[9:5];
						first_q <= rq.bit_index[9:5];
						last_q  <= (rq.operation == OP_ANY) ? rc_m1[9:5] : rq.bit_index[9:5];
						ans_q   <= 1'b0;
						if (((rq.operation == OP_GET || rq.operation == OP_SET) && idx_ok)
								|| (rq.operation == OP_ANY && range_ok)) begin
							state_q <= ST_WALK;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_WALK: begin
					unique case (op_q)
						OP_GET: begin
							ans_q   <= bit_sel;
							state_q <= ST_DONE;
						end
						OP_ANY: begin
							if (hit) begin
								ans_q   <= 1'b1;
								state_q <= ST_DONE;
							end else if (w_q == last_q) begin
								ans_q   <= 1'b0;
								state_q <= ST_DONE;
							end else begin
								w_q <= w_q + WIDX_W'(1);
							end
						end
						default: begin
							ans_q   <= 1'b0;
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_ans_q   <= ans_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
